FILE: rtl/xalu_pkg.sv
// ----------------------------------------------------------------------------
// xalu_pkg : shared types and constants for the 16-bit ALU and branch unit
// Holds the mode codes, the decoded instruction word passed from the front
// end to the execute stage, and the register code decoder.
// ----------------------------------------------------------------------------
package xalu_pkg;

	// Default depth of the queue between decode and execute.
	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	// Flag positions in the status word.
	localparam int unsigned FLAG_CF = 0;
	localparam int unsigned FLAG_PF = 1;
	localparam int unsigned FLAG_AF = 2;
	localparam int unsigned FLAG_ZF = 3;
	localparam int unsigned FLAG_SF = 4;
	localparam int unsigned FLAG_OF = 5;
	localparam int unsigned FLAG_W  = 6;

	// Slot of CX in the general register file.
	localparam logic [2:0] SLOT_CX = 3'd2;

	// Instruction modes as they arrive on the input.
	typedef enum logic [3:0] {
		MODE_MOV    = 4'd0,
		MODE_ADD    = 4'd1,
		MODE_SUB    = 4'd2,
		MODE_CMP    = 4'd3,
		MODE_JNZ    = 4'd4,
		MODE_JZ     = 4'd5,
		MODE_JNB    = 4'd6,
		MODE_JB     = 4'd7,
		MODE_JNP    = 4'd8,
		MODE_JP     = 4'd9,
		MODE_LOOPNZ = 4'd10,
		MODE_LOOPZ  = 4'd11
	} mode_t;

	// Operation class after decode.
	typedef enum logic [2:0] {
		OP_NOP,
		OP_MOV,
		OP_ADD,
		OP_SUB,
		OP_CMP,
		OP_JCC,
		OP_LOOP
	} op_t;

	// Source selection.
	typedef enum logic [1:0] {
		SRC_GEN,
		SRC_SEG,
		SRC_IMM
	} src_t;

	// Which part of a general register is addressed.
	typedef enum logic [1:0] {
		PART_WORD,
		PART_LO,
		PART_HI
	} part_t;

	// Source kind codes on the input.
	localparam logic [1:0] KIND_GEN = 2'd0;
	localparam logic [1:0] KIND_SEG = 2'd1;

	typedef struct packed {
		logic [2:0] slot;
		part_t      part;
	} reg_sel_t;

	// Decoded instruction word held in the queue.
	typedef struct packed {
		op_t         op;
		logic [2:0]  cond_bit;
		logic        cond_neg;
		logic        dst_seg;
		logic [2:0]  dst_slot;
		part_t       dst_part;
		src_t        src_sel;
		logic [2:0]  src_slot;
		part_t       src_part;
		logic [15:0] imm;
	} dec_t;

	// Queue status seen by the front end and the checks.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Register code to slot and part: codes below twelve come in groups of
	// three (word, low byte, high byte), the last four are SI, DI, SP, BP.
	function automatic reg_sel_t reg_decode(input logic [3:0] code);
		reg_sel_t sel;
		case (code)
			4'd0:    sel = '{slot: 3'd0, part: PART_WORD};
			4'd1:    sel = '{slot: 3'd0, part: PART_LO};
			4'd2:    sel = '{slot: 3'd0, part: PART_HI};
			4'd3:    sel = '{slot: 3'd1, part: PART_WORD};
			4'd4:    sel = '{slot: 3'd1, part: PART_LO};
			4'd5:    sel = '{slot: 3'd1, part: PART_HI};
			4'd6:    sel = '{slot: 3'd2, part: PART_WORD};
			4'd7:    sel = '{slot: 3'd2, part: PART_LO};
			4'd8:    sel = '{slot: 3'd2, part: PART_HI};
			4'd9:    sel = '{slot: 3'd3, part: PART_WORD};
			4'd10:   sel = '{slot: 3'd3, part: PART_LO};
			4'd11:   sel = '{slot: 3'd3, part: PART_HI};
			4'd12:   sel = '{slot: 3'd4, part: PART_WORD};
			4'd13:   sel = '{slot: 3'd5, part: PART_WORD};
			4'd14:   sel = '{slot: 3'd6, part: PART_WORD};
			default: sel = '{slot: 3'd7, part: PART_WORD};
		endcase
		return sel;
	endfunction

	// Read a register part, byte parts zero-extended.
	function automatic logic [15:0] part_read(input logic [15:0] v, input part_t part);
		logic [15:0] r;
		case (part)
			PART_LO: r = {8'h00, v[7:0]};
			PART_HI: r = {8'h00, v[15:8]};
			default: r = v;
		endcase
		return r;
	endfunction

	// Merge a value into a register part.
	function automatic logic [15:0] part_write(input logic [15:0] v, input part_t part,
			input logic [15:0] val);
		logic [15:0] r;
		case (part)
			PART_LO: r = {v[15:8], val[7:0]};
			PART_HI: r = {val[7:0], v[7:0]};
			default: r = val;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/xalu_front.sv
// ----------------------------------------------------------------------------
// xalu_front : instruction intake and decode
// Accepts input words while the queue has room and turns the raw fields into
// an operation class, register slots and parts, and a branch condition.
// ----------------------------------------------------------------------------
module xalu_front (
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [3:0]             mode,
	input  logic                   dst_kind,
	input  logic [3:0]             dst_index,
	input  logic [1:0]             src_kind,
	input  logic [3:0]             src_index,
	input  logic [15:0]            imm_value,
	input  xalu_pkg::q_stat_t      q_stat,
	output logic                   push,
	output xalu_pkg::dec_t         dec
);
	import xalu_pkg::*;

	reg_sel_t dsel;
	reg_sel_t ssel;

	// A word is taken whenever the queue is not full.
	assign in_ready = !q_stat.full;
	assign push     = in_valid && !q_stat.full;

	assign dsel = reg_decode(dst_index);
	assign ssel = reg_decode(src_index);

	// Field decode.
	always_comb begin
		dec          = '0;
		dec.imm      = imm_value;
		dec.cond_neg = !mode[0];
		dec.cond_bit = 3'(FLAG_ZF);

		case (mode)
			MODE_MOV:             dec.op = OP_MOV;
			MODE_ADD:             dec.op = OP_ADD;
			MODE_SUB:             dec.op = OP_SUB;
			MODE_CMP:             dec.op = OP_CMP;
			MODE_JNZ, MODE_JZ:    dec.op = OP_JCC;
			MODE_JNB, MODE_JB: begin
				dec.op       = OP_JCC;
				dec.cond_bit = 3'(FLAG_CF);
			end
			MODE_JNP, MODE_JP: begin
				dec.op       = OP_JCC;
				dec.cond_bit = 3'(FLAG_PF);
			end
			MODE_LOOPNZ, MODE_LOOPZ: dec.op = OP_LOOP;
			default:              dec.op = OP_NOP;
		endcase

		// Destination: segment registers use only the low two index bits.
		dec.dst_seg = dst_kind;
		if (dst_kind) begin
			dec.dst_slot = {1'b0, dst_index[1:0]};
			dec.dst_part = PART_WORD;
		end else begin
			dec.dst_slot = dsel.slot;
			dec.dst_part = dsel.part;
		end

		// Source: kinds two and three behave as an immediate.
		case (src_kind)
			KIND_GEN: begin
				dec.src_sel  = SRC_GEN;
				dec.src_slot = ssel.slot;
				dec.src_part = ssel.part;
			end
			KIND_SEG: begin
				dec.src_sel  = SRC_SEG;
				dec.src_slot = {1'b0, src_index[1:0]};
				dec.src_part = PART_WORD;
			end
			default: begin
				dec.src_sel  = SRC_IMM;
				dec.src_slot = 3'd0;
				dec.src_part = PART_WORD;
			end
		endcase
	end

endmodule

FILE: rtl/xalu_queue.sv
// ----------------------------------------------------------------------------
// xalu_queue : decoded instruction queue
// A small first-in first-out buffer that lets decode and execute stall
// independently of each other.
// ----------------------------------------------------------------------------
module xalu_queue #(
	parameter int unsigned DEPTH = xalu_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  xalu_pkg::dec_t    push_word,
	input  logic              pop,
	output xalu_pkg::dec_t    head,
	output xalu_pkg::q_stat_t q_stat
);
	import xalu_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	dec_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head         = entry_q[rd_ptr_q];
	assign q_stat.full  = (count_q == CNT_FULL);
	assign q_stat.empty = (count_q == '0);

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

FILE: rtl/xalu_exec.sv
// ----------------------------------------------------------------------------
// xalu_exec : execute stage
// Holds the architectural registers, flags and instruction pointer, carries
// out the instruction at the head of the queue and registers the result word.
// ----------------------------------------------------------------------------
module xalu_exec (
	input  logic              clk,
	input  logic              arst_n,
	input  xalu_pkg::dec_t    head,
	input  xalu_pkg::q_stat_t q_stat,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [15:0]       old_value,
	output logic [15:0]       new_value,
	output logic [5:0]        flag_bits,
	output logic [15:0]       next_ip
);
	import xalu_pkg::*;

	logic [15:0] gen_q [8];
	logic [15:0] seg_q [4];
	logic [FLAG_W-1:0] flags_q;
	logic [15:0] ip_q;
	logic        out_valid_q;

	logic        byte_w;
	logic [15:0] d_word;
	logic [15:0] d;
	logic [15:0] s_raw;
	logic [15:0] s;
	logic [16:0] sum;
	logic [15:0] r;
	logic        is_sub;
	logic        d_top;
	logic        s_top;
	logic        r_top;
	logic        ovf;
	logic [FLAG_W-1:0] arith_flags;
	logic [15:0] cx_dec;
	logic        cond;

	logic        gen_we;
	logic [2:0]  gen_waddr;
	logic [15:0] gen_wdata;
	logic        seg_we;
	logic [FLAG_W-1:0] flags_nxt;
	logic [15:0] ip_nxt;
	logic [15:0] old_nxt;
	logic [15:0] new_nxt;

	// The head is taken whenever the result register is free or draining.
	assign pop       = !q_stat.empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	// Operand fetch, width taken from the destination.
	assign byte_w = !head.dst_seg && (head.dst_part != PART_WORD);
	assign d_word = head.dst_seg ? seg_q[head.dst_slot[1:0]] : gen_q[head.dst_slot];
	assign d      = part_read(d_word, head.dst_part);

	always_comb begin
		case (head.src_sel)
			SRC_GEN: s_raw = part_read(gen_q[head.src_slot], head.src_part);
			SRC_SEG: s_raw = seg_q[head.src_slot[1:0]];
			default: s_raw = head.imm;
		endcase
	end

	assign s = byte_w ? {8'h00, s_raw[7:0]} : s_raw;

	// Adder with carry or borrow out of the operating width.
	assign is_sub = (head.op != OP_ADD);
	assign sum    = is_sub ? ({1'b0, d} - {1'b0, s}) : ({1'b0, d} + {1'b0, s});
	assign r      = byte_w ? {8'h00, sum[7:0]} : sum[15:0];

	assign d_top = byte_w ? d[7] : d[15];
	assign s_top = byte_w ? s[7] : s[15];
	assign r_top = byte_w ? r[7] : r[15];
	assign ovf   = is_sub ? ((d_top ^ s_top) & (d_top ^ r_top))
	                      : (~(d_top ^ s_top) & (d_top ^ r_top));

	always_comb begin
		arith_flags          = '0;
		arith_flags[FLAG_CF] = byte_w ? sum[8] : sum[16];
		arith_flags[FLAG_PF] = ~^r[7:0];
		arith_flags[FLAG_AF] = d[4] ^ s[4] ^ r[4];
		arith_flags[FLAG_ZF] = (r == 16'h0000);
		arith_flags[FLAG_SF] = r_top;
		arith_flags[FLAG_OF] = ovf;
	end

	// Branch condition, shared by conditional jumps and loops.
	assign cx_dec = gen_q[SLOT_CX] - 16'd1;
	assign cond   = flags_q[head.cond_bit] ^ head.cond_neg;

	// Next architectural state and result values.
	always_comb begin
		gen_we    = 1'b0;
		gen_waddr = head.dst_slot;
		gen_wdata = part_write(gen_q[head.dst_slot], head.dst_part, r);
		seg_we    = 1'b0;
		flags_nxt = flags_q;
		ip_nxt    = ip_q;
		old_nxt   = 16'h0000;
		new_nxt   = 16'h0000;

		case (head.op)
			OP_MOV: begin
				gen_we    = !head.dst_seg;
				seg_we    = head.dst_seg;
				gen_wdata = part_write(gen_q[head.dst_slot], head.dst_part, s);
				old_nxt   = d;
				new_nxt   = s;
			end
			OP_ADD, OP_SUB: begin
				gen_we    = !head.dst_seg;
				seg_we    = head.dst_seg;
				flags_nxt = arith_flags;
				old_nxt   = d;
				new_nxt   = r;
			end
			OP_CMP: begin
				flags_nxt = arith_flags;
			end
			OP_JCC: begin
				if (cond) begin
					ip_nxt = ip_q + head.imm;
				end
			end
			OP_LOOP: begin
				gen_we    = 1'b1;
				gen_waddr = SLOT_CX;
				gen_wdata = cx_dec;
				if ((cx_dec != 16'h0000) && cond) begin
					ip_nxt = ip_q + head.imm;
				end
			end
			default: begin
			end
		endcase
	end

	// Architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				gen_q[i] <= '0;
			end
			for (int i = 0; i < 4; i++) begin
				seg_q[i] <= '0;
			end
			flags_q <= '0;
			ip_q    <= '0;
		end else if (pop) begin
			if (gen_we) begin
				gen_q[gen_waddr] <= gen_wdata;
			end
			if (seg_we) begin
				seg_q[head.dst_slot[1:0]] <= new_nxt;
			end
			flags_q <= flags_nxt;
			ip_q    <= ip_nxt;
		end
	end

	// Result word valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result word payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			old_value <= old_nxt;
			new_value <= new_nxt;
			flag_bits <= flags_nxt;
			next_ip   <= ip_nxt;
		end
	end

endmodule

FILE: rtl/x86_16bit_alu_branch_exec.sv
// ----------------------------------------------------------------------------
// x86_16bit_alu_branch_exec : 16-bit ALU and branch execution unit
// Decodes and executes MOV, ADD, SUB, CMP, conditional jumps and loops on
// general and segment registers, returning one result word per instruction.
// ----------------------------------------------------------------------------
// One instruction word is accepted per clock while the queue has room, and one
// result word is produced for each. A word is decoded in the cycle it is
// accepted, waits in a QUEUE_DEPTH-entry queue, and is executed when it
// reaches the head. The result register loads at the end of the execute cycle,
// and while the output takes each result word the sustained rate is one word
// per cycle.
// Registers, flags and the instruction pointer update at the end of the execute
// cycle, so dependent instructions follow one another without gaps.
// Decode keeps accepting while a result waits on the output until the queue
// fills.
module x86_16bit_alu_branch_exec #(
	parameter int unsigned QUEUE_DEPTH = xalu_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  mode,
	input  logic        dst_kind,
	input  logic [3:0]  dst_index,
	input  logic [1:0]  src_kind,
	input  logic [3:0]  src_index,
	input  logic [15:0] imm_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] old_value,
	output logic [15:0] new_value,
	output logic [5:0]  flag_bits,
	output logic [15:0] next_ip
);
	import xalu_pkg::*;

	dec_t    dec;
	dec_t    head;
	q_stat_t q_stat;
	logic    push;
	logic    pop;

	// Intake and decode.
	xalu_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.dst_kind  (dst_kind),
		.dst_index (dst_index),
		.src_kind  (src_kind),
		.src_index (src_index),
		.imm_value (imm_value),
		.q_stat    (q_stat),
		.push      (push),
		.dec       (dec)
	);

	// Queue between decode and execute.
	xalu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (dec),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	// Execution and result register.
	xalu_exec u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.old_value (old_value),
		.new_value (new_value),
		.flag_bits (flag_bits),
		.next_ip   (next_ip)
	);

	// The queue cannot be both full and empty.
	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue reports full and empty together");

	// Execute never takes a word from an empty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("execute popped an empty queue");

	// A word pushed without a pop leaves the queue occupied.
	a_push_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> !q_stat.empty)
		else $error("pushed word lost from queue");

	// An executed word always produces a result word next cycle.
	a_pop_result: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid)
		else $error("executed word produced no result");

endmodule
